>>> rtl/flow_rate_step_admission_core_macros.svh
// Assertion macros for the flow rate step admission core.
`ifndef FLOW_RATE_STEP_ADMISSION_CORE_MACROS_SVH
`define FLOW_RATE_STEP_ADMISSION_CORE_MACROS_SVH
`ifndef NO_ASSERTIONS
`define FRSA_ASSERT_ALWAYS(label, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);
`define FRSA_ASSERT_NEXT(label, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error("next-cycle check failed");
`else
`define FRSA_ASSERT_ALWAYS(label, cond, msg)
`define FRSA_ASSERT_NEXT(label, pre, post)
`endif
`endif

>>> rtl/frsa_pkg.sv
// Package with types and constants of the flow rate step admission core.
package frsa_pkg;
    typedef enum logic [1:0] {
        ACT_STEP  = 2'd0,
        ACT_QUERY = 2'd1,
        ACT_UTIL  = 2'd2,
        ACT_ON    = 2'd3
    } action_t;

    typedef enum logic [3:0] {
        ST_IDLE, ST_EXEC, ST_PEN0, ST_PEN1, ST_PEN2, ST_PEN3,
        ST_MP0, ST_MP1, ST_MP2, ST_MP3, ST_RATE, ST_DVLD, ST_DIV, ST_DONE
    } state_t;

    localparam logic [2:0] REG_QTHRESH  = 3'd0;
    localparam logic [2:0] REG_NSTEPS   = 3'd1;
    localparam logic [2:0] REG_TOPRATE  = 3'd2;
    localparam logic [2:0] REG_DELTA    = 3'd3;
    localparam logic [2:0] REG_AVGINT   = 3'd4;
    localparam logic [2:0] REG_RESTART  = 3'd5;
    localparam logic [2:0] REG_UTILVAL  = 3'd6;
    localparam logic [2:0] REG_AVGCAP   = 3'd7;

    localparam logic [34:0] RST_QTHRESH = 35'd65536;
    localparam logic [7:0]  RST_NSTEPS  = 8'd8;
    localparam logic [31:0] RST_TOPRATE = 32'd1000000;
    localparam logic [16:0] RST_DELTA   = 17'd58982;
    localparam logic [23:0] RST_AVGINT  = 24'd30000;
    localparam logic [23:0] RST_RESTART = 24'd6000000;
    localparam logic [7:0]  RST_UTILVAL = 8'd1;
    localparam logic [23:0] RST_AVGCAP  = 24'd50000;

    localparam logic [16:0] Q16_ONE     = 17'd65536;
    localparam logic [19:0] INERTIA_INC = 20'd10000;
    localparam logic [19:0] INERTIA_MAX = 20'd300000;
    localparam logic [5:0]  DIV_LAST    = 6'd39;
endpackage

>>> rtl/flow_rate_step_admission_core.sv
// Top level of the flow rate step admission core with its sequencer and shared multiplier.
//
//   channel | signals                                      | handshake
//   input   | action, now_us, queue_bytes                  | in_valid / in_ready
//   output  | rate_bps, step_level, flow_on, triaged,      | out_valid / out_ready
//           | utility, accepted                            |
//   config  | cfg_index, cfg_data                          | cfg_we, no wait
//
// An item's time is dominated by the 40-step restoring divider of the rate,
// and penalty and limit products run through one shared 33 x 25 multiplier.
// Reset loads the register defaults and the flow starts on at step one.
// A result waits in the output register until taken; a new item is taken meanwhile,
// and its own result waits in the last state while the previous one is still held.
`include "flow_rate_step_admission_core_macros.svh"

module flow_rate_step_admission_core (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [1:0]  action,
    input  logic [47:0] now_us,
    input  logic [31:0] queue_bytes,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [31:0] rate_bps,
    output logic [7:0]  step_level,
    output logic        flow_on,
    output logic        triaged,
    output logic [7:0]  utility,
    output logic        accepted,
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [34:0] cfg_data
);
    frsa_pkg::state_t state_reg, state_next;

    logic [34:0] qthresh_reg, qthresh_next;
    logic [7:0]  nsteps_reg, nsteps_next;
    logic [31:0] top_reg, top_next;
    logic [16:0] delta_reg, delta_next;
    logic [23:0] restart_reg, restart_next;
    logic [7:0]  utilval_reg, utilval_next;
    logic [23:0] avgcap_reg, avgcap_next;

    logic        on_reg, on_next;
    logic [7:0]  step_reg, step_next;
    logic [7:0]  lsu_reg, lsu_next;
    logic [31:0] lrate_reg, lrate_next;
    logic [63:0] pen_reg, pen_next;
    logic [47:0] elap_reg, elap_next;
    logic [47:0] lut_reg, lut_next;
    logic [47:0] iet_reg, iet_next;
    logic [23:0] cavg_reg, cavg_next;
    logic [19:0] inert_reg, inert_next;
    logic [7:0]  unow_reg, unow_next;

    frsa_pkg::action_t act_reg, act_next;
    logic [47:0] now_reg, now_next;
    logic        qover_reg, qover_next;
    logic [47:0] el_reg, el_next;
    logic        acc_reg, acc_next;
    logic        tri_reg, tri_next;

    logic [57:0] prod_reg, prod_next;
    logic [57:0] hold_reg, hold_next;
    logic [15:0] alo_reg, alo_next;
    logic [63:0] add_reg, add_next;
    logic [39:0] dvd_reg, dvd_next;
    logic [8:0]  rem_reg, rem_next;
    logic [5:0]  cnt_reg, cnt_next;

    logic        ov_reg, ov_next;
    logic [31:0] o_rate_reg, o_rate_next;
    logic [7:0]  o_step_reg, o_step_next;
    logic        o_on_reg, o_on_next;
    logic        o_tri_reg, o_tri_next;
    logic [7:0]  o_util_reg, o_util_next;
    logic        o_acc_reg, o_acc_next;

    logic [32:0] mul_a;
    logic [24:0] mul_b;
    logic [7:0]  n_eff;
    logic [31:0] diff;
    logic [16:0] dsat;
    logic [24:0] tsum;
    logic [79:0] pen_prod;
    logic [64:0] pen_sum;
    logic [48:0] elap_sum;
    logic [63:0] mp;
    logic        over_lim;
    logic [8:0]  dbl;
    logic [8:0]  up_sum;
    logic [8:0]  rem_sh;
    logic [31:0] rate_q;
    logic [19:0] inert_grown;
    logic        in_fire;

    assign in_fire  = in_valid && in_ready;
    assign in_ready = (state_reg == frsa_pkg::ST_IDLE);

    assign n_eff    = (nsteps_reg == 8'd0) ? 8'd1 : nsteps_reg;
    assign diff     = (top_reg > lrate_reg) ? top_reg - lrate_reg : 32'd0;
    assign dsat     = (delta_reg > frsa_pkg::Q16_ONE) ? frsa_pkg::Q16_ONE : delta_reg;
    assign tsum     = 25'(cavg_reg) + 25'(inert_reg);
    assign pen_prod = (80'(prod_reg) << 24) + 80'(hold_reg);
    assign pen_sum  = 65'(pen_reg) + 65'(add_reg);
    assign elap_sum = 49'(elap_reg) + 49'(el_reg);
    assign mp       = 64'(hold_reg) + 64'(prod_reg[57:16]);
    assign over_lim = pen_reg > mp;
    assign dbl      = {lsu_reg, 1'b0};
    assign rem_sh   = {rem_reg[7:0], dvd_reg[39]};
    assign rate_q   = (dvd_reg[39:32] != 8'd0) ? 32'hFFFF_FFFF : dvd_reg[31:0];
    assign inert_grown = (inert_reg < frsa_pkg::INERTIA_MAX) ?
                         inert_reg + frsa_pkg::INERTIA_INC : inert_reg;

    always_comb
    begin
        lsu_next = lsu_reg;
        if (!qover_reg && lsu_reg != 8'd0)
        begin
            lsu_next = (dbl < 9'(n_eff)) ? dbl[7:0] : n_eff;
        end
        else if (!qover_reg)
        begin
            lsu_next = 8'd1;
        end
        up_sum = 9'(step_reg) + 9'(lsu_next);
    end

    always_comb
    begin
        mul_a = 33'd0;
        mul_b = 25'd0;
        case (state_reg)
            frsa_pkg::ST_PEN0:
            begin
                mul_a = {1'b0, diff};
                mul_b = {1'b0, el_reg[23:0]};
            end
            frsa_pkg::ST_PEN1:
            begin
                mul_a = {1'b0, diff};
                mul_b = {1'b0, el_reg[47:24]};
            end
            frsa_pkg::ST_MP0:
            begin
                mul_a = {1'b0, top_reg};
                mul_b = 25'(frsa_pkg::Q16_ONE - dsat);
            end
            frsa_pkg::ST_MP1:
            begin
                mul_a = prod_reg[48:16];
                mul_b = tsum;
            end
            frsa_pkg::ST_MP2:
            begin
                mul_a = {17'd0, alo_reg};
                mul_b = tsum;
            end
            frsa_pkg::ST_RATE:
            begin
                mul_a = {1'b0, top_reg};
                mul_b = {17'd0, step_reg};
            end
            default:
            begin
                mul_a = 33'd0;
                mul_b = 25'd0;
            end
        endcase
        prod_next = 58'(mul_a) * 58'(mul_b);
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            frsa_pkg::ST_IDLE: if (in_fire) state_next = frsa_pkg::ST_EXEC;
            frsa_pkg::ST_EXEC:
            begin
                state_next = frsa_pkg::ST_RATE;
                if (on_reg && act_reg == frsa_pkg::ACT_QUERY && lut_reg != 48'd0 &&
                    lsu_reg == 8'd0)
                begin
                    state_next = frsa_pkg::ST_PEN0;
                end
                else if (on_reg && act_reg == frsa_pkg::ACT_UTIL)
                begin
                    state_next = (lut_reg != 48'd0 && lsu_reg == 8'd0) ?
                                 frsa_pkg::ST_PEN0 : frsa_pkg::ST_MP0;
                end
            end
            frsa_pkg::ST_PEN0: state_next = frsa_pkg::ST_PEN1;
            frsa_pkg::ST_PEN1: state_next = frsa_pkg::ST_PEN2;
            frsa_pkg::ST_PEN2: state_next = frsa_pkg::ST_PEN3;
            frsa_pkg::ST_PEN3:
                state_next = (act_reg == frsa_pkg::ACT_UTIL) ? frsa_pkg::ST_MP0 :
                             frsa_pkg::ST_RATE;
            frsa_pkg::ST_MP0: state_next = frsa_pkg::ST_MP1;
            frsa_pkg::ST_MP1: state_next = frsa_pkg::ST_MP2;
            frsa_pkg::ST_MP2: state_next = frsa_pkg::ST_MP3;
            frsa_pkg::ST_MP3: state_next = frsa_pkg::ST_RATE;
            frsa_pkg::ST_RATE: state_next = frsa_pkg::ST_DVLD;
            frsa_pkg::ST_DVLD: state_next = frsa_pkg::ST_DIV;
            frsa_pkg::ST_DIV:
                if (cnt_reg == frsa_pkg::DIV_LAST) state_next = frsa_pkg::ST_DONE;
            frsa_pkg::ST_DONE: if (!ov_reg || out_ready) state_next = frsa_pkg::ST_IDLE;
            default: state_next = frsa_pkg::ST_IDLE;
        endcase
    end

    always_comb
    begin
        qthresh_next = qthresh_reg;
        nsteps_next  = nsteps_reg;
        top_next     = top_reg;
        delta_next   = delta_reg;
        restart_next = restart_reg;
        utilval_next = utilval_reg;
        avgcap_next  = avgcap_reg;
        on_next      = on_reg;
        step_next    = step_reg;
        lrate_next   = lrate_reg;
        pen_next     = pen_reg;
        elap_next    = elap_reg;
        lut_next     = lut_reg;
        iet_next     = iet_reg;
        cavg_next    = cavg_reg;
        inert_next   = inert_reg;
        unow_next    = unow_reg;
        act_next     = act_reg;
        now_next     = now_reg;
        qover_next   = qover_reg;
        el_next      = el_reg;
        acc_next     = acc_reg;
        tri_next     = tri_reg;
        hold_next    = hold_reg;
        alo_next     = alo_reg;
        add_next     = add_reg;
        dvd_next     = dvd_reg;
        rem_next     = rem_reg;
        cnt_next     = cnt_reg;
        ov_next      = ov_reg && !out_ready;
        o_rate_next  = o_rate_reg;
        o_step_next  = o_step_reg;
        o_on_next    = o_on_reg;
        o_tri_next   = o_tri_reg;
        o_util_next  = o_util_reg;
        o_acc_next   = o_acc_reg;

        if (cfg_we)
        begin
            case (cfg_index)
                frsa_pkg::REG_QTHRESH: qthresh_next = cfg_data;
                frsa_pkg::REG_NSTEPS:  nsteps_next  = cfg_data[7:0];
                frsa_pkg::REG_TOPRATE: top_next     = cfg_data[31:0];
                frsa_pkg::REG_DELTA:   delta_next   = cfg_data[16:0];
                frsa_pkg::REG_AVGINT:
                begin
                    cavg_next = cfg_data[23:0];
                    iet_next  = 48'(cfg_data[23:0]);
                end
                frsa_pkg::REG_RESTART: restart_next = cfg_data[23:0];
                frsa_pkg::REG_UTILVAL: utilval_next = cfg_data[7:0];
                frsa_pkg::REG_AVGCAP:  avgcap_next  = cfg_data[23:0];
                default: qthresh_next = qthresh_reg;
            endcase
        end

        case (state_reg)
            frsa_pkg::ST_IDLE:
            begin
                if (in_fire)
                begin
                    act_next   = frsa_pkg::action_t'(action);
                    now_next   = now_us;
                    qover_next = {queue_bytes, 3'b000} > qthresh_reg;
                    el_next    = (now_us >= lut_reg) ? now_us - lut_reg : 48'd0;
                    acc_next   = 1'b0;
                    tri_next   = 1'b0;
                end
            end
            frsa_pkg::ST_EXEC:
            begin
                case (act_reg)
                    frsa_pkg::ACT_STEP:
                    begin
                        if (on_reg)
                        begin
                            acc_next = 1'b1;
                            if (qover_reg)
                            begin
                                if (step_reg != 8'd0) step_next = step_reg - 8'd1;
                            end
                            else
                            begin
                                step_next = (up_sum < 9'(n_eff)) ? up_sum[7:0] : n_eff;
                            end
                        end
                    end
                    frsa_pkg::ACT_QUERY:
                    begin
                        if (on_reg)
                        begin
                            acc_next = 1'b1;
                            if (lut_reg == 48'd0 || lsu_reg != 8'd0)
                            begin
                                if (lut_reg != 48'd0)
                                begin
                                    elap_next = elap_sum[48] ? 48'hFFFF_FFFF_FFFF :
                                                elap_sum[47:0];
                                end
                                lut_next = now_reg;
                            end
                        end
                    end
                    frsa_pkg::ACT_UTIL:
                    begin
                        if (on_reg)
                        begin
                            acc_next = 1'b1;
                            if (!(lut_reg != 48'd0 && lsu_reg == 8'd0))
                            begin
                                elap_next = elap_sum[48] ? 48'hFFFF_FFFF_FFFF :
                                            elap_sum[47:0];
                            end
                        end
                    end
                    default:
                    begin
                        if (!on_reg && now_reg >= lut_reg &&
                            now_reg - lut_reg >= 48'(restart_reg))
                        begin
                            acc_next   = 1'b1;
                            on_next    = 1'b1;
                            step_next  = 8'd1;
                            elap_next  = 48'd0;
                            pen_next   = 64'd0;
                            inert_next = 20'd0;
                            lut_next   = now_reg;
                            if (avgcap_reg < cavg_reg)
                            begin
                                cavg_next = avgcap_reg;
                                iet_next  = now_reg + 48'(avgcap_reg);
                            end
                            else
                            begin
                                iet_next = now_reg + 48'(cavg_reg);
                            end
                        end
                    end
                endcase
            end
            frsa_pkg::ST_PEN1: hold_next = prod_reg;
            frsa_pkg::ST_PEN2:
                add_next = (pen_prod[79:64] != 16'd0) ? 64'hFFFF_FFFF_FFFF_FFFF :
                           pen_prod[63:0];
            frsa_pkg::ST_PEN3:
            begin
                pen_next  = pen_sum[64] ? 64'hFFFF_FFFF_FFFF_FFFF : pen_sum[63:0];
                elap_next = elap_sum[48] ? 48'hFFFF_FFFF_FFFF : elap_sum[47:0];
                if (act_reg == frsa_pkg::ACT_QUERY) lut_next = now_reg;
            end
            frsa_pkg::ST_MP1: alo_next = prod_reg[15:0];
            frsa_pkg::ST_MP2: hold_next = prod_reg;
            frsa_pkg::ST_MP3:
            begin
                if (over_lim)
                begin
                    on_next   = 1'b0;
                    unow_next = 8'd0;
                    tri_next  = 1'b1;
                end
                else
                begin
                    lut_next = now_reg;
                    if (now_reg > iet_reg && elap_reg != 48'd0)
                    begin
                        unow_next  = utilval_reg;
                        inert_next = inert_grown;
                        pen_next   = 64'd0;
                        elap_next  = 48'd0;
                        iet_next   = now_reg + 48'(cavg_reg) + 48'(inert_grown);
                    end
                end
            end
            frsa_pkg::ST_DVLD:
            begin
                dvd_next = prod_reg[39:0];
                rem_next = 9'd0;
                cnt_next = 6'd0;
            end
            frsa_pkg::ST_DIV:
            begin
                cnt_next = cnt_reg + 6'd1;
                if (rem_sh >= 9'(n_eff))
                begin
                    rem_next = rem_sh - 9'(n_eff);
                    dvd_next = {dvd_reg[38:0], 1'b1};
                end
                else
                begin
                    rem_next = rem_sh;
                    dvd_next = {dvd_reg[38:0], 1'b0};
                end
            end
            frsa_pkg::ST_DONE:
            begin
                if (!ov_reg || out_ready)
                begin
                    ov_next     = 1'b1;
                    o_rate_next = on_reg ? rate_q : 32'd0;
                    o_step_next = step_reg;
                    o_on_next   = on_reg;
                    o_tri_next  = tri_reg;
                    o_util_next = unow_reg;
                    o_acc_next  = acc_reg;
                    if (act_reg == frsa_pkg::ACT_QUERY && on_reg) lrate_next = rate_q;
                end
            end
            default: cnt_next = cnt_reg;
        endcase
    end

    logic [7:0] lsu_upd;
    always_comb
    begin
        lsu_upd = lsu_reg;
        if (state_reg == frsa_pkg::ST_EXEC && act_reg == frsa_pkg::ACT_STEP && on_reg)
        begin
            lsu_upd = qover_reg ? 8'd0 : lsu_next;
        end
        else if (state_reg == frsa_pkg::ST_MP3 && over_lim)
        begin
            lsu_upd = 8'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= frsa_pkg::ST_IDLE;
            qthresh_reg <= frsa_pkg::RST_QTHRESH;
            nsteps_reg  <= frsa_pkg::RST_NSTEPS;
            top_reg     <= frsa_pkg::RST_TOPRATE;
            delta_reg   <= frsa_pkg::RST_DELTA;
            restart_reg <= frsa_pkg::RST_RESTART;
            utilval_reg <= frsa_pkg::RST_UTILVAL;
            avgcap_reg  <= frsa_pkg::RST_AVGCAP;
            on_reg      <= 1'b1;
            step_reg    <= 8'd1;
            lsu_reg     <= 8'd1;
            lrate_reg   <= 32'd0;
            pen_reg     <= 64'd0;
            elap_reg    <= 48'd0;
            lut_reg     <= 48'd0;
            iet_reg     <= 48'(frsa_pkg::RST_AVGINT);
            cavg_reg    <= frsa_pkg::RST_AVGINT;
            inert_reg   <= 20'd0;
            unow_reg    <= 8'd0;
            act_reg     <= frsa_pkg::ACT_STEP;
            now_reg     <= 48'd0;
            qover_reg   <= 1'b0;
            el_reg      <= 48'd0;
            acc_reg     <= 1'b0;
            tri_reg     <= 1'b0;
            prod_reg    <= 58'd0;
            hold_reg    <= 58'd0;
            alo_reg     <= 16'd0;
            add_reg     <= 64'd0;
            dvd_reg     <= 40'd0;
            rem_reg     <= 9'd0;
            cnt_reg     <= 6'd0;
            ov_reg      <= 1'b0;
            o_rate_reg  <= 32'd0;
            o_step_reg  <= 8'd0;
            o_on_reg    <= 1'b0;
            o_tri_reg   <= 1'b0;
            o_util_reg  <= 8'd0;
            o_acc_reg   <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            qthresh_reg <= qthresh_next;
            nsteps_reg  <= nsteps_next;
            top_reg     <= top_next;
            delta_reg   <= delta_next;
            restart_reg <= restart_next;
            utilval_reg <= utilval_next;
            avgcap_reg  <= avgcap_next;
            on_reg      <= on_next;
            step_reg    <= step_next;
            lsu_reg     <= lsu_upd;
            lrate_reg   <= lrate_next;
            pen_reg     <= pen_next;
            elap_reg    <= elap_next;
            lut_reg     <= lut_next;
            iet_reg     <= iet_next;
            cavg_reg    <= cavg_next;
            inert_reg   <= inert_next;
            unow_reg    <= unow_next;
            act_reg     <= act_next;
            now_reg     <= now_next;
            qover_reg   <= qover_next;
            el_reg      <= el_next;
            acc_reg     <= acc_next;
            tri_reg     <= tri_next;
            prod_reg    <= prod_next;
            hold_reg    <= hold_next;
            alo_reg     <= alo_next;
            add_reg     <= add_next;
            dvd_reg     <= dvd_next;
            rem_reg     <= rem_next;
            cnt_reg     <= cnt_next;
            ov_reg      <= ov_next;
            o_rate_reg  <= o_rate_next;
            o_step_reg  <= o_step_next;
            o_on_reg    <= o_on_next;
            o_tri_reg   <= o_tri_next;
            o_util_reg  <= o_util_next;
            o_acc_reg   <= o_acc_next;
        end
    end

    assign out_valid  = ov_reg;
    assign rate_bps   = o_rate_reg;
    assign step_level = o_step_reg;
    assign flow_on    = o_on_reg;
    assign triaged    = o_tri_reg;
    assign utility    = o_util_reg;
    assign accepted   = o_acc_reg;

    `FRSA_ASSERT_ALWAYS(a_triage_off, !(ov_reg && o_tri_reg && o_on_reg), "triaged item on")
    `FRSA_ASSERT_NEXT(a_busy_after_accept, in_fire, !in_ready)
    `FRSA_ASSERT_ALWAYS(a_div_count, !(state_reg == frsa_pkg::ST_DIV && cnt_reg > frsa_pkg::DIV_LAST), "div overrun")
endmodule
